@@ rtl/initial_bearing_between_points_core_macros.svh @@
// Assertion macros for the bearing core checker.
`ifndef INITIAL_BEARING_BETWEEN_POINTS_CORE_MACROS_SVH
`define INITIAL_BEARING_BETWEEN_POINTS_CORE_MACROS_SVH

// pre holds now, post holds in the next cycle
`define IBP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bearing core: next-cycle check failed");

// pre implies post in the same cycle
`define IBP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bearing core: same-cycle check failed");

`endif

@@ rtl/ibp_pkg.sv @@
// Shared types, constants and the arctangent table of the bearing core.
package ibp_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int RW = 36;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_K = PI_Q60 / 64'd1800000000;

    localparam logic signed [RW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [RW-1:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [31:0] BEARING_MAX = 32'sd1686629713;

    localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
    localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

    typedef struct packed {
        logic [RW-1:0] x;
        logic [RW-1:0] y;
        logic [RW-1:0] z;
        logic          neg;
    } rot_t;

    typedef struct packed {
        logic [RW-1:0] x;
        logic [RW-1:0] y;
        logic [RW-1:0] z;
        logic          zero;
    } vec_t;

    function automatic logic signed [RW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [RW-1:0] v;
        case (idx)
            5'd0: v = 36'sd843314856;
            5'd1: v = 36'sd497837829;
            5'd2: v = 36'sd263043836;
            5'd3: v = 36'sd133525158;
            5'd4: v = 36'sd67021686;
            5'd5: v = 36'sd33543515;
            5'd6: v = 36'sd16775850;
            5'd7: v = 36'sd8388437;
            5'd8: v = 36'sd4194282;
            5'd9: v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd7;
            5'd28: v = 36'sd3;
            5'd29: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/ibp_rot_cell.sv @@
// One rotation-mode CORDIC cell (sin/cos lane).
module ibp_rot_cell (
    input  logic          clk,
    input  logic          en,
    input  logic [4:0]    stage,
    input  ibp_pkg::rot_t d,
    output ibp_pkg::rot_t q
);
    import ibp_pkg::*;

    rot_t q_reg;
    rot_t q_next;

    always_comb
    begin
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;
        x  = d.x;
        y  = d.y;
        z  = d.z;
        dx = y >>> stage;
        dy = x >>> stage;
        q_next.neg = d.neg;
        if (!z[RW-1])
        begin
            q_next.x = x - dx;
            q_next.y = y + dy;
            q_next.z = z - atan_q30(stage);
        end
        else
        begin
            q_next.x = x + dx;
            q_next.y = y - dy;
            q_next.z = z + atan_q30(stage);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/ibp_vec_cell.sv @@
// One vectoring-mode CORDIC cell (atan2 lane).
module ibp_vec_cell (
    input  logic          clk,
    input  logic          en,
    input  logic [4:0]    stage,
    input  ibp_pkg::vec_t d,
    output ibp_pkg::vec_t q
);
    import ibp_pkg::*;

    vec_t q_reg;
    vec_t q_next;

    always_comb
    begin
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;
        x  = d.x;
        y  = d.y;
        z  = d.z;
        dx = y >>> stage;
        dy = x >>> stage;
        q_next.zero = d.zero;
        if (!y[RW-1])
        begin
            q_next.x = x + dx;
            q_next.y = y - dy;
            q_next.z = z + atan_q30(stage);
        end
        else
        begin
            q_next.x = x - dx;
            q_next.y = y + dy;
            q_next.z = z - atan_q30(stage);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/ibp_angle_prep.sv @@
// Angle folding to a quarter turn and conversion to Q30 radians, four stages.
module ibp_angle_prep (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [32:0]                 angle,
    output logic signed [ibp_pkg::RW-1:0]      z,
    output logic                               neg
);
    import ibp_pkg::*;

    logic signed [33:0] r1_reg, r1_next;
    logic signed [33:0] r2_reg, r2_next;
    logic signed [30:0] r3_reg, r3_next;
    logic               n3_reg, n3_next;
    logic signed [RW-1:0] z_reg, z_next;
    logic               n4_reg;

    always_comb
    begin
        logic signed [33:0] a;
        logic signed [33:0] t;
        logic signed [63:0] prod;
        logic signed [63:0] rr;
        a = 34'(angle);
        if (a >= FULL_TURN)
            r1_next = a - FULL_TURN;
        else if (a <= -FULL_TURN)
            r1_next = a + FULL_TURN;
        else
            r1_next = a;

        if (r1_reg >= HALF_TURN)
            r2_next = r1_reg - FULL_TURN;
        else if (r1_reg < -HALF_TURN)
            r2_next = r1_reg + FULL_TURN;
        else
            r2_next = r1_reg;

        t = r2_reg;
        n3_next = 1'b0;
        if (r2_reg > QUARTER_TURN)
        begin
            t = r2_reg - HALF_TURN;
            n3_next = 1'b1;
        end
        else if (r2_reg < -QUARTER_TURN)
        begin
            t = r2_reg + HALF_TURN;
            n3_next = 1'b1;
        end
        r3_next = t[30:0];

        rr = 64'(r3_reg);
        prod = rr * $signed({32'd0, RAD_K[31:0]});
        z_next = RW'((prod + 64'sd536870912) >>> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            r3_reg <= r3_next;
            n3_reg <= n3_next;
            z_reg  <= z_next;
            n4_reg <= n3_reg;
        end
    end

    assign z   = z_reg;
    assign neg = n4_reg;

endmodule

@@ rtl/initial_bearing_between_points_core.sv @@
// Accepts one transfer per cycle whenever the pipeline advances.
// Three rows of rotation CORDIC cells and one row of vectoring cells, one cell per stage.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears only the valid line; payload registers are not reset.
// Top level of the initial great-circle bearing core.
module initial_bearing_between_points_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [30:0] origin_latitude,
    input  logic signed [31:0] origin_longitude,
    input  logic signed [30:0] target_latitude,
    input  logic signed [31:0] target_longitude,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] bearing_radians
);
    import ibp_pkg::*;

    localparam int LAT = 11 + 2 * NSTG;

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;

    logic signed [32:0] ang_reg [3];
    logic signed [RW-1:0] pz [3];
    logic pneg [3];

    rot_t rot_ch [3][NSTG+1];

    // sign-applied trig: 0 lat1, 1 lat2, 2 dlon
    logic signed [31:0] sn_reg [3];
    logic signed [31:0] cs_reg [3];

    logic signed [31:0] y1_reg, p1_reg, q1_reg, cd1_reg;
    logic signed [31:0] y2_reg, p2_reg, t2_reg;
    logic signed [32:0] y3_reg, x3_reg;

    vec_t vec_ch [NSTG+1];
    vec_t v0_reg, v0_next;

    logic signed [31:0] bearing_reg, bearing_next;

    assign en = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    function automatic logic signed [31:0] rnd_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = 64'(a) * 64'(b);
        r = (p + 64'sd536870912) >>> 30;
        return r[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= 33'(origin_latitude);
            ang_reg[1] <= 33'(target_latitude);
            ang_reg[2] <= 33'(target_longitude) - 33'(origin_longitude);
        end
    end

    genvar k, i;
    generate
        for (k = 0; k < 3; k++)
        begin : g_lane
            ibp_angle_prep u_prep (
                .clk   (clk),
                .en    (en),
                .angle (ang_reg[k]),
                .z     (pz[k]),
                .neg   (pneg[k])
            );

            always_comb
            begin
                rot_ch[k][0].x   = GAIN_Q30;
                rot_ch[k][0].y   = '0;
                rot_ch[k][0].z   = pz[k];
                rot_ch[k][0].neg = pneg[k];
            end

            for (i = 0; i < NSTG; i++)
            begin : g_cell
                ibp_rot_cell u_cell (
                    .clk   (clk),
                    .en    (en),
                    .stage (5'(i)),
                    .d     (rot_ch[k][i]),
                    .q     (rot_ch[k][i+1])
                );
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rot_ch[k][NSTG].neg)
                    begin
                        sn_reg[k] <= 32'(-$signed(rot_ch[k][NSTG].y));
                        cs_reg[k] <= 32'(-$signed(rot_ch[k][NSTG].x));
                    end
                    else
                    begin
                        sn_reg[k] <= rot_ch[k][NSTG].y[31:0];
                        cs_reg[k] <= rot_ch[k][NSTG].x[31:0];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg  <= rnd_mul(sn_reg[2], cs_reg[1]);
            p1_reg  <= rnd_mul(cs_reg[0], sn_reg[1]);
            q1_reg  <= rnd_mul(sn_reg[0], cs_reg[1]);
            cd1_reg <= cs_reg[2];
            y2_reg  <= y1_reg;
            p2_reg  <= p1_reg;
            t2_reg  <= rnd_mul(q1_reg, cd1_reg);
            y3_reg  <= 33'(y2_reg);
            x3_reg  <= 33'(p2_reg) - 33'(t2_reg);
            v0_reg  <= v0_next;
            bearing_reg <= bearing_next;
        end
    end

    always_comb
    begin
        logic signed [RW-1:0] xe;
        logic signed [RW-1:0] ye;
        xe = RW'(x3_reg);
        ye = RW'(y3_reg);
        v0_next.zero = (x3_reg == '0) && (y3_reg == '0);
        if (xe[RW-1])
        begin
            v0_next.x = -xe;
            v0_next.y = -ye;
            v0_next.z = ye[RW-1] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            v0_next.x = xe;
            v0_next.y = ye;
            v0_next.z = '0;
        end
    end

    assign vec_ch[0] = v0_reg;

    generate
        for (i = 0; i < NSTG; i++)
        begin : g_vec
            ibp_vec_cell u_cell (
                .clk   (clk),
                .en    (en),
                .stage (5'(i)),
                .d     (vec_ch[i]),
                .q     (vec_ch[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        logic signed [RW-1:0] b;
        b = ($signed(vec_ch[NSTG].z) + RW'(1)) >>> 1;
        if (vec_ch[NSTG].zero)
            bearing_next = '0;
        else if (b > RW'(BEARING_MAX))
            bearing_next = BEARING_MAX;
        else if (b < -RW'(BEARING_MAX))
            bearing_next = -BEARING_MAX;
        else
            bearing_next = b[31:0];
    end

    assign out_valid       = vld_reg[LAT-1];
    assign bearing_radians = bearing_reg;

endmodule

@@ rtl/ibp_checker.sv @@
// Port-level checker for the bearing core, with its bind.
`include "initial_bearing_between_points_core_macros.svh"

module ibp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] bearing_radians
);
    import ibp_pkg::*;

    `IBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bearing_radians))
    `IBP_ASSERT_NOW(a_range, out_valid, bearing_radians <= BEARING_MAX && bearing_radians >= -BEARING_MAX)
    `IBP_ASSERT_NOW(a_ready, 1'b1, in_ready == (!out_valid || out_ready))

endmodule

bind initial_bearing_between_points_core ibp_checker u_ibp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .bearing_radians (bearing_radians)
);
